FILE: sv/fbld_pkg.sv
// Package for the frame-memory line drawer: types, codes and shared helpers.
`timescale 1ns / 1ps
`default_nettype none

package fbld_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int COORD_W = 10;           // input coordinate width
  localparam int GEO_W   = 11;           // geometry register width
  localparam int POS_W   = GEO_W + 2;    // signed walk position, room for overshoot
  localparam int ERR_W   = 2 * COORD_W + 2;
  localparam int PIX_W   = 16;

  localparam logic [GEO_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [GEO_W-1:0] HEIGHT_RST = 11'd768;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [PIX_W-1:0]   color;
  } fbld_in_t;

  typedef struct packed {
    logic             status;
    logic [PIX_W-1:0] pixel_value;
  } fbld_out_t;

  typedef logic signed [POS_W-1:0] pos_t;

  function automatic logic in_area(pos_t x, pos_t y,
                                   logic [GEO_W-1:0] w, logic [GEO_W-1:0] h);
    in_area = (x >= 0) && (y >= 0) &&
              (x < $signed(POS_W'(w))) && (y < $signed(POS_W'(h)));
  endfunction

endpackage

`default_nettype wire

FILE: sv/fbld_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fbld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: sv/framebuffer_line_drawer_top.sv
// Top level of the frame-memory line drawer: command sequencer, line walk and APB registers.
`timescale 1ns / 1ps
`default_nettype none

// Frame-memory line drawer. A single-port frame RAM of MAX_WIDTH*MAX_HEIGHT
// 16-bit words, addressed y*width+x, serves three commands: write a pixel,
// read a pixel, draw a line. A command is taken when start is high and busy
// is low; busy then stays high until the single result is strobed on
// out_valid for one cycle (the receiver cannot stall, so capture it then).
// busy is already low in the result cycle, so the next command may be issued
// in that same cycle. A write, a rejected command or an unused code is
// answered from the dispatch state; a read passes through a read state
// first; a line passes through an init state and then walks the line in
// the plot state. The line walk visits one position per cycle because
// every plot is one RAM write through the one write port. The frame RAM
// has no reset and no clearing pass; reading a pixel never written returns
// whatever the RAM holds. active_width (byte address 0) and active_height
// (byte address 4) are clamped to MAX_WIDTH and MAX_HEIGHT when used; only
// write them while the block is idle.

module framebuffer_line_drawer_top #(
  parameter int MAX_WIDTH  = fbld_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fbld_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire fbld_pkg::fbld_in_t in_item,
  // result channel
  output logic                    out_valid,
  output fbld_pkg::fbld_out_t     out_result,
  // APB register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  import fbld_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_LINE_INIT = 3'd2;
  localparam logic [2:0] S_PLOT      = 3'd3;
  localparam logic [2:0] S_READ      = 3'd4;

  // line walk modes
  localparam logic [1:0] M_VERT    = 2'd0;
  localparam logic [1:0] M_HORZ    = 2'd1;
  localparam logic [1:0] M_STEEP   = 2'd2;
  localparam logic [1:0] M_SHALLOW = 2'd3;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [2:0]               state_r, state_nxt;
  fbld_in_t                 req_r, req_nxt;
  pos_t                     cx_r, cx_nxt;
  pos_t                     cy_r, cy_nxt;
  logic [COORD_W-1:0]       adx_r, adx_nxt;
  logic [COORD_W-1:0]       ady_r, ady_nxt;
  logic                     xneg_r, xneg_nxt;
  logic                     yneg_r, yneg_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic [COORD_W-1:0]       hi_r, hi_nxt;
  logic signed [ERR_W-1:0]  ex_r, ex_nxt;
  logic signed [ERR_W-1:0]  ey_r, ey_nxt;
  logic                     out_valid_r, out_valid_nxt;
  fbld_out_t                out_result_r, out_result_nxt;
  logic [GEO_W-1:0]         active_width_r, active_height_r;

  // ---------------------------------------------------------------------------
  // Effective geometry and addressing
  // ---------------------------------------------------------------------------
  logic [GEO_W-1:0] eff_w, eff_h;

  always_comb begin
    eff_w = (int'(active_width_r) > MAX_WIDTH) ? GEO_W'(MAX_WIDTH) : active_width_r;
    eff_h = (int'(active_height_r) > MAX_HEIGHT) ? GEO_W'(MAX_HEIGHT) : active_height_r;
  end

  // Frame RAM address always comes from the current position; it is only
  // meaningful (and only written) when the position is inside the area.
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [PIX_W-1:0] mem_rdata;
  logic             cur_in;

  assign mem_addr = AW'(AW'(cy_r[POS_W-2:0]) * AW'(eff_w) + AW'(cx_r[POS_W-2:0]));
  assign cur_in   = in_area(cx_r, cy_r, eff_w, eff_h);

  fbld_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req_r.color),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Command decode helpers
  // ---------------------------------------------------------------------------
  logic signed [COORD_W:0] ddx, ddy;
  logic [COORD_W-1:0]      abs_dx, abs_dy;
  logic                    end_in;

  always_comb begin
    ddx    = $signed({1'b0, req_r.end_x}) - $signed({1'b0, req_r.start_x});
    ddy    = $signed({1'b0, req_r.end_y}) - $signed({1'b0, req_r.start_y});
    abs_dx = ddx[COORD_W] ? COORD_W'(-ddx) : COORD_W'(ddx);
    abs_dy = ddy[COORD_W] ? COORD_W'(-ddy) : COORD_W'(ddy);
    end_in = in_area(pos_t'(req_r.end_x), pos_t'(req_r.end_y), eff_w, eff_h);
  end

  // Initial error terms: both start at dx*dy, with the first outer-loop
  // decrement folded into the product.
  logic                      steep;
  logic [2*COORD_W-1:0]      prod_x, prod_y;

  always_comb begin
    steep  = (mode_r == M_STEEP);
    prod_x = (2*COORD_W)'(adx_r - COORD_W'(steep)) * (2*COORD_W)'(ady_r);
    prod_y = (2*COORD_W)'(adx_r) * (2*COORD_W)'(ady_r - COORD_W'(!steep));
  end

  // One walk step
  pos_t                    step_x, step_y;
  logic signed [ERR_W-1:0] ex_dec, ey_dec;

  always_comb begin
    step_x = xneg_r ? cx_r - pos_t'(1) : cx_r + pos_t'(1);
    step_y = yneg_r ? cy_r - pos_t'(1) : cy_r + pos_t'(1);
    ex_dec = ex_r - $signed(ERR_W'(ady_r));
    ey_dec = ey_r - $signed(ERR_W'(adx_r));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    adx_nxt        = adx_r;
    ady_nxt        = ady_r;
    xneg_nxt       = xneg_r;
    yneg_nxt       = yneg_r;
    mode_nxt       = mode_r;
    hi_nxt         = hi_r;
    ex_nxt         = ex_r;
    ey_nxt         = ey_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    mem_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          cx_nxt    = pos_t'(in_item.start_x);
          cy_nxt    = pos_t'(in_item.start_y);
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        out_result_nxt.pixel_value = '0;
        unique case (req_r.operation)
          OP_WRITE: begin
            mem_we                = cur_in;
            out_result_nxt.status = !cur_in;
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
          end
          OP_READ: begin
            if (cur_in) begin
              state_nxt = S_READ;
            end else begin
              out_result_nxt.status = 1'b1;
              out_valid_nxt         = 1'b1;
              state_nxt             = S_IDLE;
            end
          end
          OP_LINE: begin
            if (cur_in && end_in) begin
              adx_nxt   = abs_dx;
              ady_nxt   = abs_dy;
              xneg_nxt  = ddx[COORD_W];
              yneg_nxt  = ddy[COORD_W];
              state_nxt = S_LINE_INIT;
              priority if (abs_dx == '0) begin
                // vertical: fill from the lower row up
                mode_nxt = M_VERT;
                cy_nxt   = ddy[COORD_W] ? pos_t'(req_r.end_y) : pos_t'(req_r.start_y);
                hi_nxt   = ddy[COORD_W] ? req_r.start_y : req_r.end_y;
              end else if (abs_dy == '0) begin
                mode_nxt = M_HORZ;
                cx_nxt   = ddx[COORD_W] ? pos_t'(req_r.end_x) : pos_t'(req_r.start_x);
                hi_nxt   = ddx[COORD_W] ? req_r.start_x : req_r.end_x;
              end else if (abs_dx < abs_dy) begin
                mode_nxt = M_STEEP;
              end else begin
                mode_nxt = M_SHALLOW;
              end
            end else begin
              out_result_nxt.status = 1'b1;
              out_valid_nxt         = 1'b1;
              state_nxt             = S_IDLE;
            end
          end
          default: begin
            // unused code: no action, success
            out_result_nxt.status = 1'b0;
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
          end
        endcase
      end

      S_LINE_INIT: begin
        ex_nxt    = $signed(ERR_W'(prod_x));
        ey_nxt    = $signed(ERR_W'(prod_y));
        state_nxt = S_PLOT;
      end

      S_PLOT: begin
        // Positions outside the area are walked but not written.
        mem_we = cur_in;
        unique case (mode_r)
          M_VERT: begin
            if (cy_r == $signed(POS_W'(hi_r))) begin
              state_nxt = S_IDLE;
            end else begin
              cy_nxt = cy_r + pos_t'(1);
            end
          end
          M_HORZ: begin
            if (cx_r == $signed(POS_W'(hi_r))) begin
              state_nxt = S_IDLE;
            end else begin
              cx_nxt = cx_r + pos_t'(1);
            end
          end
          M_STEEP: begin
            cy_nxt = step_y;
            ey_nxt = ey_dec;
            if (!(ey_dec >= ex_r)) begin
              cx_nxt = step_x;
              if (ex_r > 0) begin
                ex_nxt = ex_dec;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
          default: begin
            // shallow walk
            cx_nxt = step_x;
            ex_nxt = ex_dec;
            if (!(ex_dec >= ey_r)) begin
              cy_nxt = step_y;
              if (ey_r > 0) begin
                ey_nxt = ey_dec;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
        endcase
        if (state_nxt == S_IDLE) begin
          out_result_nxt.status      = 1'b0;
          out_result_nxt.pixel_value = '0;
          out_valid_nxt              = 1'b1;
        end
      end

      S_READ: begin
        out_result_nxt.status      = 1'b0;
        out_result_nxt.pixel_value = mem_rdata;
        out_valid_nxt              = 1'b1;
        state_nxt                  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    adx_r        <= adx_nxt;
    ady_r        <= ady_nxt;
    xneg_r       <= xneg_nxt;
    yneg_r       <= yneg_nxt;
    mode_r       <= mode_nxt;
    hi_r         <= hi_nxt;
    ex_r         <= ex_nxt;
    ey_r         <= ey_nxt;
    out_result_r <= out_result_nxt;
  end

  // ---------------------------------------------------------------------------
  // APB registers: word-addressed by paddr[2], low address bits ignored
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= WIDTH_RST;
      active_height_r <= HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HEIGHT) begin
        active_height_r <= pwdata[GEO_W-1:0];
      end else begin
        active_width_r <= pwdata[GEO_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WIDTH) begin
      prdata = 32'(active_width_r);
    end else begin
      prdata = 32'(active_height_r);
    end
  end

  assign pready     = 1'b1;
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

FILE: sv/fbld_checker.sv
// Port-level checker for the frame-memory line drawer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fbld_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire fbld_pkg::fbld_out_t out_result
);

  import fbld_pkg::*;

  // an accepted command keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  // the result is strobed in the cycle the block becomes free
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // one result per command: strobe lasts a single cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a finished command always produces its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result transfer");

  // rejected commands return no pixel data
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.status |-> out_result.pixel_value == '0)
    else $error("error result carries pixel data");

endmodule

bind framebuffer_line_drawer_top fbld_checker u_fbld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);

`default_nettype wire
